// ===== rtl/ptw_pkg.sv =====
// Shared constants for the page table walker with frame eviction.
// No dependencies.
package ptw_pkg;
  localparam int OFFSET_BITS = 4;
  localparam int LEVELS = 2;
  localparam int FRAME_COUNT = 64;
  localparam int DATA_BITS = 32;
  localparam int PAGE_WORDS = 1 << OFFSET_BITS;
  localparam int PAGE_BITS = OFFSET_BITS * LEVELS;
  localparam int PAGE_COUNT = 1 << PAGE_BITS;
  localparam int VA_BITS = OFFSET_BITS * (LEVELS + 1);
  localparam int FRAME_BITS = $clog2(FRAME_COUNT);
  localparam int FA_BITS = FRAME_BITS + OFFSET_BITS;
  localparam int SA_BITS = PAGE_BITS + OFFSET_BITS;
  localparam int LVL_BITS = $clog2(LEVELS + 1);
  localparam int DEP_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;
endpackage

// ===== rtl/ptw_dist.sv =====
// Cyclic page distance unit, shared by every leaf visit of the tree scan.
// Depends on ptw_pkg.
module ptw_dist (
  input  logic [ptw_pkg::PAGE_BITS-1:0] p,
  input  logic [ptw_pkg::PAGE_BITS-1:0] q,
  output logic [ptw_pkg::PAGE_BITS:0]   distance
);
  import ptw_pkg::*;
  logic [PAGE_BITS:0] d;
  logic [PAGE_BITS:0] e;
  always_comb begin
    d = (p > q) ? {1'b0, p - q} : {1'b0, q - p};
    e = (PAGE_BITS+1)'(PAGE_COUNT) - d;
    distance = (e < d) ? e : d;
  end
endmodule

// ===== rtl/page_table_walk_with_frame_eviction_top.sv =====
// Top level: sequencer for the walk, the depth-first scan, eviction and restore.
// Depends on ptw_pkg and ptw_dist.
//
//   channel | signals                                      | dir
//   in      | in_valid in_ready opcode virtual_address write_data | in
//   out     | out_valid out_ready read_data ok             | out
//
// One transaction at a time; in_ready is high only while idle.
// With every entry present each level's entry is read before the access; an out of range
// address goes straight to the result, and a swapped-out page is first restored word by word.
// Each zero entry adds a depth-first scan of the table words, picking and linking a frame,
// evicting a victim page when no frame is free, and clearing the frame if it holds a table.
// rst clears control state and the swap marks; frame 0 is then cleared word by word
// before the first transaction.
module page_table_walk_with_frame_eviction_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [12:0] virtual_address,
  input  logic signed [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] read_data,
  output logic        ok
);
  import ptw_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_ENT = 4'd2, S_ENTW = 4'd3,
    S_SCAN = 4'd4, S_SCANW = 4'd5, S_DEC = 4'd6, S_EVC = 4'd7, S_CLR = 4'd8,
    S_LINK = 4'd9, S_RST = 4'd10, S_ACC = 4'd11, S_ACCW = 4'd12, S_OUT = 4'd13;

  logic [DATA_BITS-1:0] fmem [FRAME_COUNT*PAGE_WORDS];
  logic [DATA_BITS-1:0] smem [PAGE_COUNT*PAGE_WORDS];
  logic [PAGE_COUNT-1:0] present;

  logic [3:0] state;
  logic op;
  logic [VA_BITS-1:0] va;
  logic [DATA_BITS-1:0] wd;
  logic [LVL_BITS-1:0] lvl;
  logic [DEP_BITS-1:0] lvl_idx;
  logic [FRAME_BITS-1:0] cur;
  logic [FRAME_BITS-1:0] path [LEVELS];
  logic [FA_BITS-1:0] addr;
  logic [OFFSET_BITS:0] cnt;

  // scan stack: per depth the frame, next index, page prefix, parent, zero flag
  logic [FRAME_BITS-1:0] sf [LEVELS];
  logic [OFFSET_BITS:0] si [LEVELS];
  logic [PAGE_BITS-1:0] sp [LEVELS];
  logic [FA_BITS-1:0] spar [LEVELS];
  logic sz [LEVELS];
  logic [DEP_BITS-1:0] dep;
  logic [FRAME_BITS:0] top;
  logic has_empty;
  logic [FRAME_BITS-1:0] empty;
  logic [FA_BITS-1:0] empty_par;
  logic [PAGE_BITS:0] best;
  logic [FRAME_BITS-1:0] victim;
  logic [FA_BITS-1:0] victim_par;
  logic [PAGE_BITS-1:0] victim_page;
  logic [FRAME_BITS-1:0] fsel;

  logic [FA_BITS-1:0] fra;
  logic [DATA_BITS-1:0] frd;
  logic [DATA_BITS-1:0] srd;
  logic [SA_BITS-1:0] sra;
  logic [DATA_BITS-1:0] res;

  logic [PAGE_BITS-1:0] want;
  logic [FRAME_BITS-1:0] ent_frame;
  logic on_path;
  logic fzero;
  logic [PAGE_BITS-1:0] lp;
  logic [PAGE_BITS:0] lp_dist;

  assign want = va[VA_BITS-1:OFFSET_BITS];
  assign ent_frame = frd[FRAME_BITS-1:0];
  assign fzero = (frd == '0);
  assign lvl_idx = lvl[DEP_BITS-1:0];
  assign lp = (sp[dep] << OFFSET_BITS) | PAGE_BITS'(si[dep][OFFSET_BITS-1:0]);

  ptw_dist u_dist (.p(lp), .q(want), .distance(lp_dist));

  always_comb begin
    on_path = (sf[dep] == '0);
    for (int k = 0; k < LEVELS; k++) begin
      if (LVL_BITS'(k) < lvl && path[k] == sf[dep]) on_path = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    frd <= fmem[fra];
    srd <= smem[sra];
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      present <= '0;
      cnt <= '0;
    end else begin
      case (state)
        S_INIT: begin
          fmem[FA_BITS'(cnt)] <= '0;
          cnt <= cnt + 1'b1;
          if (cnt == (OFFSET_BITS+1)'(PAGE_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode;
            wd <= DATA_BITS'(write_data);
            va <= virtual_address[VA_BITS-1:0];
            res <= '0;
            ok <= 1'b0;
            lvl <= '0;
            cur <= '0;
            cnt <= '0;
            if (virtual_address >= 13'(1 << VA_BITS)) state <= S_OUT;
            else state <= S_ENT;
          end
        end
        S_ENT: begin
          addr <= {cur, va[(LEVELS-int'(lvl))*OFFSET_BITS +: OFFSET_BITS]};
          fra <= {cur, va[(LEVELS-int'(lvl))*OFFSET_BITS +: OFFSET_BITS]};
          state <= S_ENTW;
        end
        S_ENTW: begin
          if (cnt == '0) cnt <= 1'b1;
          else begin
            cnt <= '0;
            if (fzero) begin
              dep <= '0;
              sf[0] <= '0; si[0] <= '0; sp[0] <= '0; spar[0] <= '0; sz[0] <= 1'b1;
              top <= '0; has_empty <= 1'b0; best <= '0;
              victim <= '0; victim_par <= '0; victim_page <= '0;
              fra <= '0;
              state <= S_SCAN;
            end else begin
              cur <= ent_frame;
              path[lvl_idx] <= ent_frame;
              lvl <= lvl + 1'b1;
              state <= (lvl == LVL_BITS'(LEVELS-1)) ? S_RST : S_ENT;
            end
          end
        end
        S_SCAN: begin
          // issue read of sf[dep] word si[dep], or pop the stack once that frame is done
          if (si[dep] == (OFFSET_BITS+1)'(PAGE_WORDS)) begin
            if (!has_empty && sz[dep] && !on_path) begin
              has_empty <= 1'b1; empty <= sf[dep]; empty_par <= spar[dep];
            end
            if (dep == '0) state <= S_DEC;
            else begin
              dep <= dep - 1'b1;
              si[dep-DEP_BITS'(1)] <= si[dep-DEP_BITS'(1)] + 1'b1;
              fra <= {sf[dep-DEP_BITS'(1)], OFFSET_BITS'(si[dep-DEP_BITS'(1)] + 1'b1)};
            end
          end else begin
            fra <= {sf[dep], si[dep][OFFSET_BITS-1:0]};
            state <= S_SCANW;
          end
        end
        S_SCANW: begin
          if (cnt == '0) cnt <= 1'b1;
          else begin
            cnt <= '0;
            state <= S_SCAN;
            if (!fzero) sz[dep] <= 1'b0;
            if (!fzero) begin
              if ({1'b0, ent_frame} > top) top <= {1'b0, ent_frame};
              if (dep == DEP_BITS'(LEVELS-1)) begin
                si[dep] <= si[dep] + 1'b1;
              end else begin
                dep <= dep + 1'b1;
                sf[dep+DEP_BITS'(1)] <= ent_frame;
                si[dep+DEP_BITS'(1)] <= '0;
                sp[dep+DEP_BITS'(1)] <= (sp[dep] << OFFSET_BITS)
                                      | PAGE_BITS'(si[dep][OFFSET_BITS-1:0]);
                spar[dep+DEP_BITS'(1)] <= {sf[dep], si[dep][OFFSET_BITS-1:0]};
                sz[dep+DEP_BITS'(1)] <= 1'b1;
              end
            end else si[dep] <= si[dep] + 1'b1;
            if (!fzero && dep == DEP_BITS'(LEVELS-1) && lp_dist > best) begin
              best <= lp_dist;
              victim <= ent_frame;
              victim_par <= {sf[dep], si[dep][OFFSET_BITS-1:0]};
              victim_page <= lp;
            end
          end
        end
        S_DEC: begin
          cnt <= '0;
          if (has_empty) begin
            fmem[empty_par] <= '0;
            fsel <= empty;
            state <= (lvl == LVL_BITS'(LEVELS-1)) ? S_LINK : S_CLR;
          end else if (top + 1'b1 < (FRAME_BITS+1)'(FRAME_COUNT)) begin
            fsel <= FRAME_BITS'(top + 1'b1);
            state <= (lvl == LVL_BITS'(LEVELS-1)) ? S_LINK : S_CLR;
          end else begin
            fsel <= victim;
            fra <= {victim, OFFSET_BITS'(0)};
            state <= S_EVC;
          end
        end
        S_EVC: begin
          // read pipeline: word cnt-1 data arrives while cnt is issued
          if (cnt != '0) smem[{victim_page, OFFSET_BITS'(cnt - 1'b1)}] <= frd;
          if (cnt == (OFFSET_BITS+1)'(PAGE_WORDS)) begin
            present[victim_page] <= 1'b1;
            fmem[victim_par] <= '0;
            cnt <= '0;
            state <= (lvl == LVL_BITS'(LEVELS-1)) ? S_LINK : S_CLR;
          end else begin
            fra <= {victim, OFFSET_BITS'(cnt + 1'b1)};
            cnt <= cnt + 1'b1;
          end
        end
        S_CLR: begin
          fmem[{fsel, cnt[OFFSET_BITS-1:0]}] <= '0;
          if (cnt == (OFFSET_BITS+1)'(PAGE_WORDS - 1)) begin
            cnt <= '0;
            state <= S_LINK;
          end else cnt <= cnt + 1'b1;
        end
        S_LINK: begin
          fmem[addr] <= DATA_BITS'(fsel);
          cur <= fsel;
          path[lvl_idx] <= fsel;
          lvl <= lvl + 1'b1;
          cnt <= '0;
          state <= (lvl == LVL_BITS'(LEVELS-1)) ? S_RST : S_ENT;
        end
        S_RST: begin
          if (!present[want]) begin
            cnt <= '0;
            state <= S_ACC;
          end else begin
            if (cnt != '0) fmem[{cur, OFFSET_BITS'(cnt - 1'b1)}] <= srd;
            if (cnt == (OFFSET_BITS+1)'(PAGE_WORDS)) begin
              present[want] <= 1'b0;
              cnt <= '0;
              state <= S_ACC;
            end else cnt <= cnt + 1'b1;
          end
        end
        S_ACC: begin
          fra <= {cur, va[OFFSET_BITS-1:0]};
          if (op == OP_WRITE) begin
            fmem[{cur, va[OFFSET_BITS-1:0]}] <= wd;
            ok <= 1'b1;
            state <= S_OUT;
          end else state <= S_ACCW;
          cnt <= '0;
        end
        S_ACCW: begin
          if (cnt == '0) cnt <= 1'b1;
          else begin
            cnt <= '0;
            res <= frd;
            ok <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sra = {want, OFFSET_BITS'(cnt[OFFSET_BITS-1:0])};
  assign read_data = res;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> read_data == '0) else $error("failed transaction data");
`endif
endmodule
